@@ rtl/tcsni_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsni_pkg
// shared types and constants of the client hello server name parser
// ----------------------------------------------------------------------------
package tcsni_pkg;

  localparam int SniMaxDefault = 256;
  localparam int PosW = 17;
  localparam logic [PosW-1:0] PosMax = 17'h1FFFF;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StShort    = 3'd1;
  localparam logic [2:0] StBadHdr   = 3'd2;
  localparam logic [2:0] StTrunc    = 3'd3;
  localparam logic [2:0] StExtLen   = 3'd4;
  localparam logic [2:0] StNameType = 3'd5;
  localparam logic [2:0] StTooLong  = 3'd6;
  localparam logic [2:0] StNone     = 3'd7;

  typedef enum logic [4:0] {
    PH_HDR, PH_SESS, PH_SUITES_HI, PH_SUITES_LO, PH_COMP, PH_EXTLEN_HI,
    PH_EXTLEN_LO, PH_ETYPE_HI, PH_ETYPE_LO, PH_ELEN_HI, PH_ELEN_LO,
    PH_ELEN_HI_SNI, PH_ELEN_LO_SNI, PH_SNILEN_HI, PH_SNILEN_LO, PH_SNITYPE,
    PH_NAMELEN_HI, PH_NAMELEN_LO, PH_NAME, PH_FOUND, PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_valid;
    logic       done_res;
    logic       found;
    logic [7:0] name_length;
    logic [2:0] status;
  } res_t;

endpackage

@@ rtl/tcsni_front.sv @@
// ----------------------------------------------------------------------------
// tcsni_front
// per-byte parser: phase tracking, offset checks and result formation
// ----------------------------------------------------------------------------
module tcsni_front #(
  parameter int SNI_MAX = tcsni_pkg::SniMaxDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output tcsni_pkg::res_t    res
);
  localparam int PW = tcsni_pkg::PosW;

  tcsni_pkg::phase_t ph_r, ph_nxt;
  logic [PW-1:0] pos_r, pos_nxt, dl_r, dl_nxt, skip_r, skip_nxt, ee_r, ee_nxt;
  logic [15:0]   acc_r, acc_nxt;
  logic [2:0]    ls_r, ls_nxt, st;
  logic [7:0]    cnl_r, cnl_nxt;

  logic [15:0]   v;
  logic [PW:0]   idx, iv, ib;
  logic          nv;

  always_comb begin
    v   = {acc_r[7:0], data_byte};
    idx = {1'b0, pos_r} + 18'd1;
    iv  = idx + {2'b0, v};
    ib  = idx + {10'b0, data_byte} + 18'd1;
  end

  always_comb begin
    logic         fl;
    logic [2:0]   fc;
    fl = 1'b0;
    fc = tcsni_pkg::StOk;
    ph_nxt = ph_r; dl_nxt = dl_r; skip_nxt = skip_r; ee_nxt = ee_r;
    acc_nxt = acc_r; ls_nxt = ls_r; cnl_nxt = cnl_r; nv = 1'b0;
    if (ph_r == tcsni_pkg::PH_NAME) begin
      nv = 1'b1;
      if (skip_r <= 17'd1) begin
        skip_nxt = '0;
        ph_nxt = tcsni_pkg::PH_FOUND;
      end else begin
        skip_nxt = skip_r - 17'd1;
      end
    end else if (skip_r != '0) begin
      skip_nxt = skip_r - 17'd1;
    end else begin
      case (ph_r)
        tcsni_pkg::PH_HDR: begin
          if (pos_r == 17'd0) begin
            if (data_byte != 8'h16) begin fl = 1'b1; fc = tcsni_pkg::StBadHdr; end
          end else if (pos_r == 17'd1) begin
            if (data_byte < 8'h03) begin fl = 1'b1; fc = tcsni_pkg::StBadHdr; end
          end else if (pos_r == 17'd3) begin
            acc_nxt = {8'b0, data_byte};
          end else if (pos_r == 17'd4) begin
            dl_nxt = {1'b0, v} + 17'd5;
          end else if (pos_r == 17'd5) begin
            if (data_byte != 8'd1) begin fl = 1'b1; fc = tcsni_pkg::StBadHdr; end
            else if (dl_r <= 17'd43) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
            else begin skip_nxt = 17'd37; ph_nxt = tcsni_pkg::PH_SESS; end
          end
        end
        tcsni_pkg::PH_SESS, tcsni_pkg::PH_COMP: begin
          if (ib >= {1'b0, dl_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else begin
            skip_nxt = {9'b0, data_byte};
            ph_nxt = (ph_r == tcsni_pkg::PH_SESS) ? tcsni_pkg::PH_SUITES_HI
                                                  : tcsni_pkg::PH_EXTLEN_HI;
          end
        end
        tcsni_pkg::PH_SUITES_HI, tcsni_pkg::PH_EXTLEN_HI, tcsni_pkg::PH_ETYPE_HI,
        tcsni_pkg::PH_ELEN_HI, tcsni_pkg::PH_ELEN_HI_SNI, tcsni_pkg::PH_SNILEN_HI,
        tcsni_pkg::PH_NAMELEN_HI: begin
          acc_nxt = {8'b0, data_byte};
          ph_nxt = tcsni_pkg::phase_t'(ph_r + 5'd1);
        end
        tcsni_pkg::PH_SUITES_LO: begin
          if (iv >= {1'b0, dl_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else begin skip_nxt = {1'b0, v}; ph_nxt = tcsni_pkg::PH_COMP; end
        end
        tcsni_pkg::PH_EXTLEN_LO: begin
          if (v == 16'd0 || iv != {1'b0, dl_r}) begin
            fl = 1'b1; fc = tcsni_pkg::StExtLen;
          end else begin
            ee_nxt = iv[PW-1:0];
            if (idx + 18'd1 >= iv) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
            else ph_nxt = tcsni_pkg::PH_ETYPE_HI;
          end
        end
        tcsni_pkg::PH_ETYPE_LO: begin
          if (idx + 18'd1 >= {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else ph_nxt = (v == 16'd0) ? tcsni_pkg::PH_ELEN_HI_SNI : tcsni_pkg::PH_ELEN_HI;
        end
        tcsni_pkg::PH_ELEN_LO: begin
          if (iv > {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else if (iv == {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StNone; end
          else if (iv + 18'd1 >= {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else begin skip_nxt = {1'b0, v}; ph_nxt = tcsni_pkg::PH_ETYPE_HI; end
        end
        tcsni_pkg::PH_ELEN_LO_SNI: begin
          if (iv > {1'b0, ee_r} || idx + 18'd1 >= {1'b0, ee_r}) begin
            fl = 1'b1; fc = tcsni_pkg::StTrunc;
          end else ph_nxt = tcsni_pkg::PH_SNILEN_HI;
        end
        tcsni_pkg::PH_SNILEN_LO: begin
          if (iv >= {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else ph_nxt = tcsni_pkg::PH_SNITYPE;
        end
        tcsni_pkg::PH_SNITYPE: begin
          if (data_byte != 8'd0) begin fl = 1'b1; fc = tcsni_pkg::StNameType; end
          else if (idx + 18'd1 >= {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else ph_nxt = tcsni_pkg::PH_NAMELEN_HI;
        end
        tcsni_pkg::PH_NAMELEN_LO: begin
          if (iv >= {1'b0, ee_r}) begin fl = 1'b1; fc = tcsni_pkg::StTrunc; end
          else if ({16'b0, v} >= 32'(SNI_MAX)) begin fl = 1'b1; fc = tcsni_pkg::StTooLong; end
          else begin
            cnl_nxt = v[7:0];
            if (v == 16'd0) ph_nxt = tcsni_pkg::PH_FOUND;
            else begin skip_nxt = {1'b0, v}; ph_nxt = tcsni_pkg::PH_NAME; end
          end
        end
        default: ;
      endcase
      if (fl) begin
        if (ls_r == tcsni_pkg::StOk) ls_nxt = fc;
        ph_nxt = tcsni_pkg::PH_IDLE;
        skip_nxt = '0;
      end
    end
    pos_nxt = (pos_r < tcsni_pkg::PosMax) ? pos_r + 17'd1 : pos_r;

    st = tcsni_pkg::StOk;
    if (last) begin
      if (idx < 18'd6) st = tcsni_pkg::StShort;
      else if (ls_nxt == tcsni_pkg::StBadHdr || idx != {1'b0, dl_nxt})
        st = tcsni_pkg::StBadHdr;
      else if (ls_nxt != tcsni_pkg::StOk) st = ls_nxt;
      else if (ph_nxt == tcsni_pkg::PH_FOUND || ph_nxt == tcsni_pkg::PH_NAME)
        st = tcsni_pkg::StOk;
      else st = tcsni_pkg::StNone;
    end
    res.name_byte   = nv ? data_byte : 8'd0;
    res.name_valid  = nv;
    res.done_res    = last;
    res.found       = last && st == tcsni_pkg::StOk;
    res.name_length = (last && st == tcsni_pkg::StOk) ? cnl_nxt : 8'd0;
    res.status      = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      ph_r <= tcsni_pkg::PH_HDR;
      pos_r <= '0; dl_r <= '0; skip_r <= '0; ee_r <= '0;
      acc_r <= '0; ls_r <= '0; cnl_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt;
      pos_r <= pos_nxt; dl_r <= dl_nxt; skip_r <= skip_nxt; ee_r <= ee_nxt;
      acc_r <= acc_nxt; ls_r <= ls_nxt; cnl_r <= cnl_nxt;
    end
  end

  a_name_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && ph_r == tcsni_pkg::PH_NAME |-> res.name_valid)
    else $error("name phase without name flag");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res.found |-> res.done_res && res.status == tcsni_pkg::StOk)
    else $error("found without ok status");
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> pos_r == '0 && ph_r == tcsni_pkg::PH_HDR)
    else $error("state not cleared after last");
endmodule

@@ rtl/tcsni_queue.sv @@
// ----------------------------------------------------------------------------
// tcsni_queue
// two-entry result queue between parser and output channel
// ----------------------------------------------------------------------------
module tcsni_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  tcsni_pkg::res_t wdata,
  output logic            space,
  output logic            rvalid,
  input  logic            rd,
  output tcsni_pkg::res_t rdata
);
  tcsni_pkg::res_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign space  = cnt_r != 2'd2;
  assign rvalid = cnt_r != 2'd0;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> space) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> rvalid) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd && cnt_r == 2'd1 |=> !space) else $error("count slip");
endmodule

@@ rtl/tls_client_hello_sni_parser.sv @@
// ----------------------------------------------------------------------------
// tls_client_hello_sni_parser
// extracts the server name from a tls client hello, one byte per item
// ----------------------------------------------------------------------------
// input channel: in_data_byte, in_last with in_valid / in_ready; one record
// byte per item, in_last on the final byte of the buffer.
// result channel: one item per input item, with out_valid / out_ready.
// host name bytes come back with out_name_valid set; the item for the last
// byte carries out_done_res, out_found, out_name_length and out_status.
// each accepted item is written into a two-entry result queue, which drives
// out_valid. the parser takes one item per cycle while the queue has space;
// counters and offset compares are updated on each accepted byte.
// when out_ready is low the queue fills and in_ready drops after two items;
// nothing is lost. reset (rst_n low, synchronous) empties the queue and
// returns the parser to the record header phase.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_parser #(
  parameter int SNI_MAX = tcsni_pkg::SniMaxDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_name_byte,
  output logic       out_name_valid,
  output logic       out_done_res,
  output logic       out_found,
  output logic [7:0] out_name_length,
  output logic [2:0] out_status
);
  tcsni_pkg::res_t res, q;
  logic step;

  assign step = in_valid && in_ready;

  tcsni_front #(.SNI_MAX(SNI_MAX)) u_front (
    .clk, .rst_n, .step, .data_byte(in_data_byte), .last(in_last), .res
  );

  tcsni_queue u_queue (
    .clk, .rst_n, .wr(step), .wdata(res), .space(in_ready),
    .rvalid(out_valid), .rd(out_valid && out_ready), .rdata(q)
  );

  assign out_name_byte   = q.name_byte;
  assign out_name_valid  = q.name_valid;
  assign out_done_res    = q.done_res;
  assign out_found       = q.found;
  assign out_name_length = q.name_length;
  assign out_status      = q.status;
endmodule
